>>> rtl/buffer_pool_with_handoff_fifo_unit_assert.svh
// ----------------------------------------------------------------------------
// Buffer pool assertion macros
// Clocked on clk, disabled while arst_n is low; empty in synthesis.
// ----------------------------------------------------------------------------
`ifndef BUFFER_POOL_WITH_HANDOFF_FIFO_UNIT_ASSERT_SVH
`define BUFFER_POOL_WITH_HANDOFF_FIFO_UNIT_ASSERT_SVH

`ifndef SYNTHESIS
// condition holds at every edge
`define BPF_ASSERT(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
		else $error("buffer pool assertion failed");
// antecedent implies consequent at the next cycle
`define BPF_ASSERT_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("buffer pool assertion failed");
`else
`define BPF_ASSERT(lbl, prop)
`define BPF_ASSERT_NEXT(lbl, ante, cons)
`endif

`endif

>>> rtl/bpf_pkg.sv
// ----------------------------------------------------------------------------
// Buffer pool package
// Sizes and command codes shared by the buffer pool files.
// ----------------------------------------------------------------------------
package bpf_pkg;

	// slot index field is 3 bits wide, so the pool and the queue hold 8
	localparam int SLOTS   = 8;
	localparam int SLOT_W  = 3;
	localparam int PTR_W   = $clog2(SLOTS);
	localparam int CNT_W   = $clog2(SLOTS + 1);
	localparam int CMD_W   = 3;

	typedef logic [CMD_W-1:0]  cmd_t;
	typedef logic [SLOT_W-1:0] slot_t;

	localparam cmd_t CMD_ALLOC   = 3'd0;
	localparam cmd_t CMD_ENQUEUE = 3'd1;
	localparam cmd_t CMD_DEQUEUE = 3'd2;
	localparam cmd_t CMD_RELEASE = 3'd3;
	localparam cmd_t CMD_SET_DONE = 3'd4;

endpackage

>>> rtl/bpf_if.sv
// ----------------------------------------------------------------------------
// Buffer pool channels
// Valid/ready request and response channels of the buffer pool.
// ----------------------------------------------------------------------------
interface bpf_req_if;
	logic           valid;
	logic           ready;
	bpf_pkg::cmd_t  cmd;
	bpf_pkg::slot_t slot_in;
	logic           done_value;

	modport source (output valid, cmd, slot_in, done_value, input ready);
	modport sink   (input valid, cmd, slot_in, done_value, output ready);
endinterface

interface bpf_rsp_if;
	logic           valid;
	logic           ready;
	bpf_pkg::slot_t slot_out;
	logic           ok;
	logic           queue_empty;
	logic           reader_done;
	logic           may_release;

	modport source (output valid, slot_out, ok, queue_empty, reader_done, may_release,
		input ready);
	modport sink   (input valid, slot_out, ok, queue_empty, reader_done, may_release,
		output ready);
endinterface

>>> rtl/buffer_pool_with_handoff_fifo_unit.sv
// ----------------------------------------------------------------------------
// Buffer pool with handoff FIFO
// Allocates the lowest free slot, releases slots, queues filled slot indices
// and keeps a reader-done flag; one response per request.
// ----------------------------------------------------------------------------
//  channel  dir  payload
//  req      in   cmd, slot_in, done_value
//  rsp      out  slot_out, ok, queue_empty, reader_done, may_release
//
//  A req transfer reaches its rsp through the input register, then the result
//  register; one request per cycle unless rsp stalls, set by the single update step.
//  Reset frees every slot, empties the queue and clears the flag.
//  A stalled rsp holds the next request in the input register; req.ready
//  drops only while both registers are full.
`include "buffer_pool_with_handoff_fifo_unit_assert.svh"

module buffer_pool_with_handoff_fifo_unit (
	input logic        clk,
	input logic        arst_n,
	bpf_req_if.sink    req,
	bpf_rsp_if.source  rsp
);

	// input register
	logic           valid_s1;
	bpf_pkg::cmd_t  cmd_s1;
	bpf_pkg::slot_t slot_s1;
	logic           done_s1;

	// state
	logic [bpf_pkg::SLOTS-1:0]  free_q;
	bpf_pkg::slot_t             entries_q [bpf_pkg::SLOTS];
	logic [bpf_pkg::PTR_W-1:0]  rd_ptr_q;
	logic [bpf_pkg::PTR_W-1:0]  wr_ptr_q;
	logic [bpf_pkg::CNT_W-1:0]  cnt_q;
	logic                       done_q;

	// result register
	logic           out_valid_q;
	bpf_pkg::slot_t slot_out_q;
	logic           ok_q;
	logic           empty_q;
	logic           rdone_q;

	// next-state logic
	logic                       advance;
	logic                       alloc_found;
	bpf_pkg::slot_t             alloc_idx;
	logic [bpf_pkg::SLOTS-1:0]  free_nxt;
	logic                       done_nxt;
	logic                       push;
	logic                       pop;
	logic [bpf_pkg::CNT_W-1:0]  cnt_nxt;
	bpf_pkg::slot_t             slot_out_nxt;
	logic                       ok_nxt;

	assign advance   = valid_s1 && (!out_valid_q || rsp.ready);
	assign req.ready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (req.ready) begin
			valid_s1 <= req.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (req.valid && req.ready) begin
			cmd_s1  <= req.cmd;
			slot_s1 <= req.slot_in;
			done_s1 <= req.done_value;
		end
	end

	// lowest free slot
	always_comb begin
		alloc_found = 1'b0;
		alloc_idx   = '0;
		for (int i = bpf_pkg::SLOTS - 1; i >= 0; i--) begin
			if (free_q[i]) begin
				alloc_found = 1'b1;
				alloc_idx   = bpf_pkg::SLOT_W'(i);
			end
		end
	end

	// slot_in always lies below SLOTS at this field width
	always_comb begin
		free_nxt     = free_q;
		done_nxt     = done_q;
		push         = 1'b0;
		pop          = 1'b0;
		slot_out_nxt = '0;
		ok_nxt       = 1'b0;
		case (cmd_s1)
			bpf_pkg::CMD_ALLOC: begin
				if (alloc_found) begin
					free_nxt[alloc_idx] = 1'b0;
					slot_out_nxt        = alloc_idx;
					ok_nxt              = 1'b1;
				end
			end
			bpf_pkg::CMD_ENQUEUE: begin
				if (cnt_q != bpf_pkg::CNT_W'(bpf_pkg::SLOTS)) begin
					push   = 1'b1;
					ok_nxt = 1'b1;
				end
			end
			bpf_pkg::CMD_DEQUEUE: begin
				if (cnt_q != '0) begin
					pop          = 1'b1;
					slot_out_nxt = entries_q[rd_ptr_q];
					ok_nxt       = 1'b1;
				end
			end
			bpf_pkg::CMD_RELEASE: begin
				free_nxt[slot_s1] = 1'b1;
			end
			bpf_pkg::CMD_SET_DONE: begin
				done_nxt = done_s1;
			end
			default: begin
			end
		endcase
	end

	always_comb begin
		if (push) begin
			cnt_nxt = cnt_q + 1'b1;
		end else if (pop) begin
			cnt_nxt = cnt_q - 1'b1;
		end else begin
			cnt_nxt = cnt_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			free_q   <= '1;
			done_q   <= 1'b0;
			cnt_q    <= '0;
			rd_ptr_q <= '0;
			wr_ptr_q <= '0;
		end else if (advance) begin
			free_q <= free_nxt;
			done_q <= done_nxt;
			cnt_q  <= cnt_nxt;
			// queue depth is a power of two, so the pointers wrap by themselves
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (advance && push) begin
			entries_q[wr_ptr_q] <= slot_s1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (rsp.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			slot_out_q <= slot_out_nxt;
			ok_q       <= ok_nxt;
			empty_q    <= (cnt_nxt == '0);
			rdone_q    <= done_nxt;
		end
	end

	assign rsp.valid       = out_valid_q;
	assign rsp.slot_out    = slot_out_q;
	assign rsp.ok          = ok_q;
	assign rsp.queue_empty = empty_q;
	assign rsp.reader_done = rdone_q;
	assign rsp.may_release = empty_q && rdone_q;

	`BPF_ASSERT(a_cnt_range, cnt_q <= bpf_pkg::CNT_W'(bpf_pkg::SLOTS))
	`BPF_ASSERT(a_empty_tracks_cnt, !out_valid_q || (empty_q == (cnt_q == '0)))
	`BPF_ASSERT_NEXT(a_alloc_taken, advance && (cmd_s1 == bpf_pkg::CMD_ALLOC) && alloc_found, !free_q[$past(alloc_idx)])
	`BPF_ASSERT_NEXT(a_pop_count, advance && pop, cnt_q == ($past(cnt_q) - 1'b1))

endmodule

>>> tb/buffer_pool_with_handoff_fifo_unit_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Buffer pool with handoff FIFO testbench
// Drives allocate, enqueue, dequeue, release and set-done requests through
// the req channel and checks every rsp transfer against a cycle-free model of
// the free map, the handoff queue and the reader-done flag. Directed tests hit
// pool exhaustion, a full and an empty queue and the unused codes; random
// traffic in phases then varies sender bursts and receiver stalls.
// ----------------------------------------------------------------------------
module buffer_pool_with_handoff_fifo_unit_tb;

	localparam int CLK_HALF    = 10;
	localparam int RESET_CYCLES = 12;
	localparam int CYCLE_LIMIT = 400000;
	localparam int MAX_REPORTS = 10;
	localparam int DRAIN_CYCLES = 8;

	typedef struct packed {
		bpf_pkg::slot_t slot_out;
		logic           ok;
		logic           queue_empty;
		logic           reader_done;
		logic           may_release;
	} pool_reply_t;

	logic clk;
	logic arst_n;

	bpf_req_if req_if ();
	bpf_rsp_if rsp_if ();

	buffer_pool_with_handoff_fifo_unit dut (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (req_if),
		.rsp    (rsp_if)
	);

	// model state
	logic [bpf_pkg::SLOTS-1:0] free_slots;
	bpf_pkg::slot_t            handoff_q[$];
	logic                      reader_done_m;
	bpf_pkg::slot_t            last_handed_off;

	pool_reply_t pending_replies[$];

	int mismatches;
	int items_sent;
	int replies_checked;
	int input_stalls;
	int cycle_count;
	int pool_exhausted_hits;
	int queue_full_hits;
	int queue_empty_hits;
	int release_allowed_hits;

	// receiver controls
	int rx_stall_pct;
	int rx_stall_max;
	int hold_off_left;

	initial begin
		clk = 1'b0;
		forever #CLK_HALF clk = ~clk;
	end

	// Next state and reply of the pool for one accepted request
	function automatic void apply_pool_cmd(input bpf_pkg::cmd_t c, input bpf_pkg::slot_t s,
		input logic d);
		pool_reply_t r;
		bit          found;
		r = '0;
		found = 1'b0;
		case (c)
			bpf_pkg::CMD_ALLOC: begin
				for (int i = 0; i < bpf_pkg::SLOTS; i++) begin
					if (!found && free_slots[i]) begin
						found = 1'b1;
						free_slots[i] = 1'b0;
						r.slot_out = bpf_pkg::slot_t'(i);
						r.ok = 1'b1;
					end
				end
				if (!found)
					pool_exhausted_hits++;
			end
			bpf_pkg::CMD_ENQUEUE: begin
				if (int'(s) < bpf_pkg::SLOTS && handoff_q.size() < bpf_pkg::SLOTS) begin
					handoff_q.push_back(s);
					r.ok = 1'b1;
				end else begin
					queue_full_hits++;
				end
			end
			bpf_pkg::CMD_DEQUEUE: begin
				if (handoff_q.size() > 0) begin
					r.slot_out = handoff_q.pop_front();
					r.ok = 1'b1;
					last_handed_off = r.slot_out;
				end else begin
					queue_empty_hits++;
				end
			end
			bpf_pkg::CMD_RELEASE: begin
				if (int'(s) < bpf_pkg::SLOTS)
					free_slots[s] = 1'b1;
			end
			bpf_pkg::CMD_SET_DONE: reader_done_m = d;
			default: ;
		endcase
		r.queue_empty = (handoff_q.size() == 0);
		r.reader_done = reader_done_m;
		r.may_release = r.queue_empty & r.reader_done;
		if (r.may_release)
			release_allowed_hits++;
		pending_replies.push_back(r);
	endfunction

	// random slot that is currently allocated if found in 2*SLOTS draws, else any slot
	function automatic bpf_pkg::slot_t pick_taken_slot();
		bpf_pkg::slot_t s;
		s = bpf_pkg::slot_t'($urandom_range(bpf_pkg::SLOTS - 1));
		for (int t = 0; t < 2 * bpf_pkg::SLOTS; t++) begin
			if (!free_slots[s])
				return s;
			s = bpf_pkg::slot_t'($urandom_range(bpf_pkg::SLOTS - 1));
		end
		return s;
	endfunction

	// Leaves valid high on return so back-to-back transfers need no extra step
	task automatic send_pool_cmd(input bpf_pkg::cmd_t c, input bpf_pkg::slot_t s,
		input logic d);
		req_if.valid      <= 1'b1;
		req_if.cmd        <= c;
		req_if.slot_in    <= s;
		req_if.done_value <= d;
		@(posedge clk);
		while (!req_if.ready)
			@(posedge clk);
		apply_pool_cmd(c, s, d);
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pause_sender(input int n);
		if (n > 0) begin
			req_if.valid <= 1'b0;
			repeat (n) @(negedge clk);
		end
	endtask

	// Receiver: random stall runs, plus a long hold-off when requested
	initial begin
		rsp_if.ready = 1'b0;
		forever begin : rx_pattern
			int stall_run;
			@(negedge clk);
			if (hold_off_left > 0) begin
				rsp_if.ready <= 1'b0;
				hold_off_left--;
			end else if (stall_run > 0) begin
				rsp_if.ready <= 1'b0;
				stall_run--;
			end else if (rx_stall_pct > 0 && $urandom_range(99) < rx_stall_pct) begin
				rsp_if.ready <= 1'b0;
				stall_run = $urandom_range(rx_stall_max);
			end else begin
				rsp_if.ready <= 1'b1;
			end
		end
	end

	task automatic report_mismatch(input string what, input pool_reply_t want,
		input pool_reply_t got);
		mismatches++;
		if (mismatches <= MAX_REPORTS)
			$display("%0t: %s exp slot=%0d ok=%b empty=%b done=%b rel=%b, got slot=%0d ok=%b empty=%b done=%b rel=%b",
				$time, what, want.slot_out, want.ok, want.queue_empty, want.reader_done,
				want.may_release, got.slot_out, got.ok, got.queue_empty, got.reader_done,
				got.may_release);
	endtask

	always @(posedge clk) begin : check_replies
		pool_reply_t want;
		pool_reply_t got;
		if (arst_n && rsp_if.valid && rsp_if.ready) begin
			got.slot_out    = rsp_if.slot_out;
			got.ok          = rsp_if.ok;
			got.queue_empty = rsp_if.queue_empty;
			got.reader_done = rsp_if.reader_done;
			got.may_release = rsp_if.may_release;
			if (pending_replies.size() == 0) begin
				report_mismatch("reply with no request pending", '0, got);
			end else begin
				want = pending_replies.pop_front();
				replies_checked++;
				if (got.slot_out !== want.slot_out || got.ok !== want.ok ||
					got.queue_empty !== want.queue_empty ||
					got.reader_done !== want.reader_done ||
					got.may_release !== want.may_release)
					report_mismatch("reply mismatch", want, got);
			end
		end
	end

	always @(posedge clk) begin
		cycle_count++;
		if (arst_n && req_if.valid && !req_if.ready)
			input_stalls++;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d replies outstanding", cycle_count,
				pending_replies.size());
			$display("buffer_pool_with_handoff_fifo_unit_tb NOT OK");
			$finish;
		end
	end

	task automatic test_empty_queue();
		send_pool_cmd(bpf_pkg::CMD_DEQUEUE, '0, 1'b0);
		send_pool_cmd(bpf_pkg::CMD_SET_DONE, '1, 1'b1);
	endtask

	// one allocate beyond the pool size
	task automatic test_pool_exhaustion();
		for (int i = 0; i <= bpf_pkg::SLOTS; i++)
			send_pool_cmd(bpf_pkg::CMD_ALLOC, '0, 1'b0);
	endtask

	// fill the queue with every index, then one push too many
	task automatic test_queue_full();
		for (int i = 0; i < bpf_pkg::SLOTS; i++)
			send_pool_cmd(bpf_pkg::CMD_ENQUEUE, bpf_pkg::slot_t'(i), 1'b0);
		pause_sender(3);
		send_pool_cmd(bpf_pkg::CMD_ENQUEUE, bpf_pkg::slot_t'(bpf_pkg::SLOTS / 2 + 1), 1'b1);
	endtask

	// taken slot freed, then freed again while already free
	task automatic test_release();
		send_pool_cmd(bpf_pkg::CMD_RELEASE, bpf_pkg::slot_t'(bpf_pkg::SLOTS - 1), 1'b0);
		send_pool_cmd(bpf_pkg::CMD_RELEASE, bpf_pkg::slot_t'(bpf_pkg::SLOTS - 1), 1'b1);
	endtask

	task automatic test_unused_codes();
		for (int c = int'(bpf_pkg::CMD_SET_DONE) + 1; c < 2 ** bpf_pkg::CMD_W; c++)
			send_pool_cmd(bpf_pkg::cmd_t'(c),
				bpf_pkg::slot_t'($urandom_range(bpf_pkg::SLOTS - 1)), 1'($urandom));
	endtask

	task automatic run_pool_traffic(input int n_items, input int gap_max);
		int             burst_left;
		bit             filling;
		int             r;
		bpf_pkg::cmd_t  c;
		bpf_pkg::slot_t s;
		burst_left = 0;
		filling = 1'b1;
		for (int n = 0; n < n_items; n++) begin
			if (n % 40 == 0)
				filling = 1'($urandom);
			if (burst_left == 0) begin
				pause_sender($urandom_range(gap_max));
				burst_left = $urandom_range(1, 16);
			end
			burst_left--;
			r = $urandom_range(99);
			s = bpf_pkg::slot_t'($urandom_range(bpf_pkg::SLOTS - 1));
			if (r < (filling ? 30 : 10)) begin
				c = bpf_pkg::CMD_ALLOC;
			end else if (r < (filling ? 60 : 22)) begin
				c = bpf_pkg::CMD_ENQUEUE;
				if ($urandom_range(99) < 75)
					s = pick_taken_slot();
			end else if (r < (filling ? 72 : 55)) begin
				c = bpf_pkg::CMD_DEQUEUE;
			end else if (r < (filling ? 84 : 88)) begin
				c = bpf_pkg::CMD_RELEASE;
				if ($urandom_range(99) < 60)
					s = last_handed_off;
				else if ($urandom_range(99) < 75)
					s = pick_taken_slot();
			end else if (r < (filling ? 96 : 97)) begin
				c = bpf_pkg::CMD_SET_DONE;
			end else begin
				c = bpf_pkg::cmd_t'(int'(bpf_pkg::CMD_SET_DONE) + 1 + $urandom_range(2));
			end
			send_pool_cmd(c, s, 1'($urandom));
		end
	endtask

	// receiver holds off long enough for both internal registers to fill
	task automatic test_backpressure();
		rx_stall_pct = 0;
		hold_off_left = 150;
		run_pool_traffic(30, 0);
	endtask

	task automatic test_random_traffic();
		rx_stall_pct = 0;  rx_stall_max = 0;  run_pool_traffic(250, 0);
		rx_stall_pct = 20; rx_stall_max = 3;  run_pool_traffic(250, 4);
		rx_stall_pct = 50; rx_stall_max = 8;  run_pool_traffic(250, 12);
		rx_stall_pct = 70; rx_stall_max = 2;  run_pool_traffic(250, 0);
		rx_stall_pct = 10; rx_stall_max = 20; run_pool_traffic(250, 20);
		rx_stall_pct = 30; rx_stall_max = 5;  run_pool_traffic(250, 2);
	endtask

	initial begin
		arst_n            = 1'b0;
		req_if.valid      = 1'b0;
		req_if.cmd        = bpf_pkg::CMD_ALLOC;
		req_if.slot_in    = '0;
		req_if.done_value = 1'b0;
		free_slots        = '1;
		reader_done_m     = 1'b0;
		last_handed_off   = '0;
		rx_stall_pct      = 25;
		rx_stall_max      = 3;
		hold_off_left     = 0;
		mismatches        = 0;
		items_sent        = 0;
		replies_checked   = 0;
		input_stalls      = 0;
		cycle_count       = 0;
		pool_exhausted_hits  = 0;
		queue_full_hits      = 0;
		queue_empty_hits     = 0;
		release_allowed_hits = 0;
		repeat (RESET_CYCLES) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);

		test_empty_queue();
		test_pool_exhaustion();
		test_queue_full();
		test_release();
		test_unused_codes();
		test_backpressure();
		test_random_traffic();

		req_if.valid <= 1'b0;
		rx_stall_pct = 0;
		while (pending_replies.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		$display("ran %0d requests, checked %0d replies, input stalled %0d cycles",
			items_sent, replies_checked, input_stalls);
		$display("pool exhausted %0d, queue full %0d, dequeue on empty %0d, release allowed %0d",
			pool_exhausted_hits, queue_full_hits, queue_empty_hits, release_allowed_hits);
		if (mismatches == 0 && pending_replies.size() == 0) begin
			$display("buffer_pool_with_handoff_fifo_unit_tb OK");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("buffer_pool_with_handoff_fifo_unit_tb NOT OK");
		end
		$finish;
	end

endmodule

>>> buffer_pool_with_handoff_fifo_unit.f
+incdir+rtl
rtl/bpf_pkg.sv
rtl/bpf_if.sv
rtl/buffer_pool_with_handoff_fifo_unit.sv
tb/buffer_pool_with_handoff_fifo_unit_tb.sv
